// ===== rtl/hjbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjbp_pkg
// Shared types, codes and helpers of the hash join build/probe engine.
// ----------------------------------------------------------------------------
package hjbp_pkg;

    localparam int DEF_BUCKETS = 1024;
    localparam int DEF_ENTRIES = 1024;
    localparam int DEF_MAX_OUT = 64;

    localparam int ATTR_W   = 32;
    localparam int SLOT_W   = 16;   // widest bucket index over the parameter range
    localparam int MASK_W   = 10;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [MASK_W-1:0] MASK_RESET = 10'd1023;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_PROBE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POOL_FULL = 2'd1;
    localparam logic [1:0] ST_TRUNC     = 2'd2;

    localparam logic [1:0] REG_BUCKET_MASK = 2'd0;
    localparam logic [1:0] REG_BUILD_COL   = 2'd1;
    localparam logic [1:0] REG_PROBE_COL   = 2'd2;

    // classified work word handed from front to back
    typedef struct packed {
        logic [1:0]        cmd;
        logic [ATTR_W-1:0] a;
        logic [ATTR_W-1:0] b;
        logic [ATTR_W-1:0] key;
        logic [3:0]        tag;
        logic [SLOT_W-1:0] slot;
    } t_op;

    typedef struct packed {
        logic              matched;
        logic [ATTR_W-1:0] probe_a;
        logic [ATTR_W-1:0] probe_b;
        logic [ATTR_W-1:0] build_a;
        logic [ATTR_W-1:0] build_b;
        logic [1:0]        status;
        logic              last;
    } t_res;

    // masked hash modulo bucket count, restoring subtraction over 8 steps
    function automatic logic [MASK_W-1:0] bucket_wrap(input logic [MASK_W-1:0] v,
                                                      input int unsigned buckets);
        logic [MASK_W-1:0] r;
        int unsigned       w;
        r = v;
        for (int k = 7; k >= 0; k--) begin
            w = buckets << k;
            if (w <= 1023 && {22'd0, r} >= w) begin
                r = r - w[MASK_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/hjbp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjbp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hjbp_ram #(
    parameter int W = 32,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/hjbp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjbp_fifo
// Two-deep register queue.
// ----------------------------------------------------------------------------
module hjbp_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== rtl/hjbp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjbp_front
// Takes words, hashes the key a byte per cycle and queues the work word.
// ----------------------------------------------------------------------------
module hjbp_front #(
    parameter int BUCKETS = hjbp_pkg::DEF_BUCKETS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic [1:0]                      i_command,
    input  logic [hjbp_pkg::ATTR_W-1:0]     i_attr_a,
    input  logic [hjbp_pkg::ATTR_W-1:0]     i_attr_b,
    input  logic [hjbp_pkg::MASK_W-1:0]     i_bucket_mask,
    input  logic                            i_build_col,
    input  logic                            i_probe_col,
    input  logic                            i_hold,
    output logic                            o_op_push,
    output hjbp_pkg::t_op                   o_op,
    input  logic                            i_op_full
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_HASH = 2'd1;
    localparam logic [1:0] F_SLOT = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]                  r_state;
    logic [1:0]                  r_step;
    logic [1:0]                  r_cmd;
    logic [hjbp_pkg::ATTR_W-1:0] r_a;
    logic [hjbp_pkg::ATTR_W-1:0] r_b;
    logic [hjbp_pkg::ATTR_W-1:0] r_key;
    logic [hjbp_pkg::ATTR_W-1:0] r_ksh;
    logic [31:0]                 r_h;
    logic [BW-1:0]               r_slot;
    logic [31:0]                 n_h;
    logic                        accept;
    logic                        key_col;

    assign o_full  = (r_state != F_IDLE) || i_hold;
    assign accept  = i_push && !o_full;
    assign key_col = (i_command == hjbp_pkg::CMD_PROBE) ? i_probe_col : i_build_col;
    // sdbm step: h * 65599 + byte
    assign n_h = {24'd0, r_ksh[7:0]} + (r_h << 6) + (r_h << 16) - r_h;

    assign o_op_push = (r_state == F_PUSH) && !i_op_full;
    always_comb begin
        o_op      = '0;
        o_op.cmd  = r_cmd;
        o_op.a    = r_a;
        o_op.b    = r_b;
        o_op.key  = r_key;
        o_op.tag  = r_h[3:0];
        o_op.slot = hjbp_pkg::SLOT_W'(r_slot);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_a   <= i_attr_a;
            r_b   <= i_attr_b;
            r_key <= key_col ? i_attr_b : i_attr_a;
            r_ksh <= key_col ? i_attr_b : i_attr_a;
            r_h   <= 32'd0;
        end else if (r_state == F_HASH) begin
            r_h   <= n_h;
            r_ksh <= r_ksh >> 8;
        end
        if (r_state == F_SLOT) begin
            r_slot <= BW'(hjbp_pkg::bucket_wrap(r_h[hjbp_pkg::MASK_W-1:0] & i_bucket_mask,
                                                BUCKETS));
        end
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= 2'd0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept && i_command != hjbp_pkg::CMD_NONE) begin
                        r_state <= F_HASH;
                        r_step  <= 2'd0;
                    end
                end
                F_HASH: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_state <= F_SLOT;
                    end
                end
                F_SLOT: r_state <= F_PUSH;
                F_PUSH: begin
                    if (!i_op_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/hjbp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjbp_back
// Executes inserts, probes and clears against the bucket and entry memories.
// ----------------------------------------------------------------------------
module hjbp_back #(
    parameter int BUCKETS = hjbp_pkg::DEF_BUCKETS,
    parameter int ENTRIES = hjbp_pkg::DEF_ENTRIES,
    parameter int MAX_OUT = hjbp_pkg::DEF_MAX_OUT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_build_col,
    input  logic          i_op_empty,
    input  hjbp_pkg::t_op i_op,
    output logic          o_op_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output hjbp_pkg::t_res o_res,
    output logic          o_clearing
);

    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int EAW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IW  = $clog2(ENTRIES + 1);
    localparam int CW  = $clog2(MAX_OUT + 1);
    localparam int AW  = hjbp_pkg::ATTR_W;
    localparam logic [IW-1:0] NULL_IDX = IW'(ENTRIES);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_HEAD = 3'd1;
    localparam logic [2:0] B_ECHK = 3'd2;
    localparam logic [2:0] B_FIN  = 3'd3;
    localparam logic [2:0] B_ONE  = 3'd4;
    localparam logic [2:0] B_CLR  = 3'd5;

    logic [2:0]    r_state, n_state;
    hjbp_pkg::t_op r_op, n_op;
    logic [IW-1:0] r_used, n_used;
    logic [BW-1:0] r_clr, n_clr;
    logic          r_clr_cmd, n_clr_cmd;
    logic          r_pend_v, n_pend_v;
    logic [AW-1:0] r_pend_a, n_pend_a;
    logic [AW-1:0] r_pend_b, n_pend_b;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_stat, n_stat;

    logic              b_we, b_re;
    logic [BW-1:0]     b_waddr, b_raddr;
    logic [IW+15:0]    b_wdata, b_rdata;
    logic              e_we, e_re;
    logic [EAW-1:0]    e_waddr, e_raddr;
    logic [2*AW+IW-1:0] e_wdata, e_rdata;

    logic [IW-1:0] bh_head;
    logic [15:0]   bh_tags;
    logic [AW-1:0] e_a, e_b, e_key;
    logic [IW-1:0] e_link;
    logic          e_hit;

    assign bh_head = b_rdata[IW+15:16];
    assign bh_tags = b_rdata[15:0];
    assign e_a     = e_rdata[2*AW+IW-1:AW+IW];
    assign e_b     = e_rdata[AW+IW-1:IW];
    assign e_link  = e_rdata[IW-1:0];
    assign e_key   = i_build_col ? e_b : e_a;
    assign e_hit   = (e_key == r_op.key);
    assign o_clearing = (r_state == B_CLR);

    hjbp_ram #(.W(IW + 16), .D(BUCKETS)) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    hjbp_ram #(.W(2 * AW + IW), .D(ENTRIES)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_re    (e_re),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_used    = r_used;
        n_clr     = r_clr;
        n_clr_cmd = r_clr_cmd;
        n_pend_v  = r_pend_v;
        n_pend_a  = r_pend_a;
        n_pend_b  = r_pend_b;
        n_cnt     = r_cnt;
        n_stat    = r_stat;
        b_we      = 1'b0;
        b_re      = 1'b0;
        b_waddr   = r_op.slot[BW-1:0];
        b_raddr   = i_op.slot[BW-1:0];
        b_wdata   = '0;
        e_we      = 1'b0;
        e_re      = 1'b0;
        e_waddr   = r_used[EAW-1:0];
        e_raddr   = bh_head[EAW-1:0];
        e_wdata   = {r_op.a, r_op.b, bh_head};
        o_op_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res     = '0;
        o_res.last = 1'b1;

        unique case (r_state)
            B_IDLE: begin
                if (!i_op_empty) begin
                    o_op_pop = 1'b1;
                    n_op     = i_op;
                    unique case (i_op.cmd)
                        hjbp_pkg::CMD_CLEAR: begin
                            n_used    = '0;
                            n_clr     = '0;
                            n_clr_cmd = 1'b1;
                            n_state   = B_CLR;
                        end
                        hjbp_pkg::CMD_INSERT: begin
                            if (r_used == NULL_IDX) begin
                                n_stat  = hjbp_pkg::ST_POOL_FULL;
                                n_state = B_ONE;
                            end else begin
                                b_re    = 1'b1;
                                n_state = B_HEAD;
                            end
                        end
                        hjbp_pkg::CMD_PROBE: begin
                            b_re    = 1'b1;
                            n_state = B_HEAD;
                        end
                        default: n_state = B_IDLE;
                    endcase
                end
            end
            B_HEAD: begin
                if (r_op.cmd == hjbp_pkg::CMD_INSERT) begin
                    // new entry goes on the chain head, tag bit set
                    e_we    = 1'b1;
                    b_we    = 1'b1;
                    b_wdata = {r_used, bh_tags | (16'd1 << r_op.tag)};
                    n_used  = r_used + IW'(1);
                    n_stat  = hjbp_pkg::ST_OK;
                    n_state = B_ONE;
                end else begin
                    n_pend_v = 1'b0;
                    n_cnt    = '0;
                    if (bh_tags[r_op.tag] && bh_head < NULL_IDX) begin
                        e_re    = 1'b1;
                        n_state = B_ECHK;
                    end else begin
                        n_state = B_FIN;
                    end
                end
            end
            B_ECHK: begin
                // a match is held back until the next one shows whether it is last
                if (!(e_hit && r_pend_v && i_res_full)) begin
                    if (e_hit && r_pend_v) begin
                        o_res_push    = 1'b1;
                        o_res.matched = 1'b1;
                        o_res.probe_a = r_op.a;
                        o_res.probe_b = r_op.b;
                        o_res.build_a = r_pend_a;
                        o_res.build_b = r_pend_b;
                    end
                    if (e_hit && r_pend_v && r_cnt == CW'(MAX_OUT)) begin
                        o_res.status = hjbp_pkg::ST_TRUNC;
                        o_res.last   = 1'b1;
                        n_pend_v     = 1'b0;
                        n_state      = B_IDLE;
                    end else begin
                        o_res.last = 1'b0;
                        if (e_hit) begin
                            n_pend_v = 1'b1;
                            n_pend_a = e_a;
                            n_pend_b = e_b;
                            n_cnt    = r_cnt + CW'(1);
                        end
                        if (e_link < NULL_IDX) begin
                            e_re    = 1'b1;
                            e_raddr = e_link[EAW-1:0];
                        end else begin
                            n_state = B_FIN;
                        end
                    end
                end
            end
            B_FIN: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_pend_v) begin
                        o_res.matched = 1'b1;
                        o_res.probe_a = r_op.a;
                        o_res.probe_b = r_op.b;
                        o_res.build_a = r_pend_a;
                        o_res.build_b = r_pend_b;
                    end
                    n_pend_v = 1'b0;
                    n_state  = B_IDLE;
                end
            end
            B_ONE: begin
                if (!i_res_full) begin
                    o_res_push   = 1'b1;
                    o_res.status = r_stat;
                    n_state      = B_IDLE;
                end
            end
            B_CLR: begin
                b_we    = 1'b1;
                b_waddr = r_clr;
                b_wdata = {NULL_IDX, 16'd0};
                n_clr   = r_clr + BW'(1);
                if (r_clr == BW'(BUCKETS - 1)) begin
                    n_stat  = hjbp_pkg::ST_OK;
                    n_state = r_clr_cmd ? B_ONE : B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pend_a <= n_pend_a;
        r_pend_b <= n_pend_b;
        r_stat   <= n_stat;
        if (!i_rst_n) begin
            r_state   <= B_CLR;
            r_used    <= '0;
            r_clr     <= '0;
            r_clr_cmd <= 1'b0;
            r_pend_v  <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_clr     <= n_clr;
            r_clr_cmd <= n_clr_cmd;
            r_pend_v  <= n_pend_v;
            r_cnt     <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_res_push && i_res_full))
        else $error("result written into full queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_OUT))
        else $error("match count past limit");
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= NULL_IDX)
        else $error("entry pool overallocated");
    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op_pop && i_op.cmd != hjbp_pkg::CMD_NONE) |=> r_state != B_IDLE)
        else $error("work word popped but not started");
`endif

endmodule

// ===== rtl/hash_join_build_probe_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_join_build_probe_top
// Chained hash join engine: insert build records, probe, clear.
// ----------------------------------------------------------------------------
// Each word pushed is hashed over its key bytes, one byte per cycle. The front
// end is busy after it takes a word (four hash steps, bucket select, queue
// write) and takes no new word until it is through with the last. The work
// word reaches the back end through a two-deep queue. An insert pops the
// queue and reads its bucket, writes the entry and the new chain head, then
// writes its result; a clear sweeps the bucket memory one bucket per cycle. A
// probe reads its bucket, then walks the chain one entry at a time from the
// registered entry RAM; a probe whose tag bit is clear skips the walk. A full
// result queue stalls the back end. After reset the back end runs the same
// sweep, during which no word is taken (configuration writes still work), and
// the input also stays full during every clear sweep. Results come out in
// order through a two-deep queue; each probe ends with last set, a probe with
// no match gives one unmatched word, and only MAX_OUT matches are given, the
// final one flagged truncated if more existed.
module hash_join_build_probe_top #(
    parameter int BUCKETS = hjbp_pkg::DEF_BUCKETS,
    parameter int ENTRIES = hjbp_pkg::DEF_ENTRIES,
    parameter int MAX_OUT = hjbp_pkg::DEF_MAX_OUT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input word queue
    input  logic                               push,
    output logic                               full,
    input  logic [1:0]                         i_command,
    input  logic signed [hjbp_pkg::ATTR_W-1:0] i_attr_a,
    input  logic signed [hjbp_pkg::ATTR_W-1:0] i_attr_b,
    // result word queue
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_matched,
    output logic signed [hjbp_pkg::ATTR_W-1:0] o_probe_a,
    output logic signed [hjbp_pkg::ATTR_W-1:0] o_probe_b,
    output logic signed [hjbp_pkg::ATTR_W-1:0] o_build_a,
    output logic signed [hjbp_pkg::ATTR_W-1:0] o_build_b,
    output logic [1:0]                         o_status,
    output logic                               o_last,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hjbp_pkg::PADDR_W-1:0]       paddr,
    input  logic [hjbp_pkg::PDATA_W-1:0]       pwdata,
    output logic [hjbp_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    logic [hjbp_pkg::MASK_W-1:0] r_bucket_mask;
    logic                        r_build_col;
    logic                        r_probe_col;
    logic                        cfg_wr;

    hjbp_pkg::t_op  fr_op, bk_op;
    hjbp_pkg::t_res bk_res, out_res;
    logic           op_push, op_full, op_pop, op_empty;
    logic           res_push, res_full;
    logic           clearing;

    // registers: bucket mask at 0x0, build key column 0x4, probe key column 0x8
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_mask <= hjbp_pkg::MASK_RESET;
            r_build_col   <= 1'b0;
            r_probe_col   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                hjbp_pkg::REG_BUCKET_MASK: r_bucket_mask <= pwdata[hjbp_pkg::MASK_W-1:0];
                hjbp_pkg::REG_BUILD_COL:   r_build_col   <= pwdata[0];
                hjbp_pkg::REG_PROBE_COL:   r_probe_col   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            hjbp_pkg::REG_BUCKET_MASK: prdata = {22'd0, r_bucket_mask};
            hjbp_pkg::REG_BUILD_COL:   prdata = {31'd0, r_build_col};
            hjbp_pkg::REG_PROBE_COL:   prdata = {31'd0, r_probe_col};
            default:                   prdata = '0;
        endcase
    end

    // front: accept, hash, classify
    hjbp_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_command     (i_command),
        .i_attr_a      (i_attr_a),
        .i_attr_b      (i_attr_b),
        .i_bucket_mask (r_bucket_mask),
        .i_build_col   (r_build_col),
        .i_probe_col   (r_probe_col),
        .i_hold        (clearing),
        .o_op_push     (op_push),
        .o_op          (fr_op),
        .i_op_full     (op_full)
    );

    // decouples front and back so each can stall on its own
    hjbp_fifo #(.W($bits(hjbp_pkg::t_op))) u_op_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_data  (fr_op),
        .o_full  (op_full),
        .i_pop   (op_pop),
        .o_data  (bk_op),
        .o_empty (op_empty)
    );

    // back: memory work and result generation
    hjbp_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES), .MAX_OUT(MAX_OUT)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_build_col (r_build_col),
        .i_op_empty  (op_empty),
        .i_op        (bk_op),
        .o_op_pop    (op_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (bk_res),
        .o_clearing  (clearing)
    );

    // result queue toward the consumer
    hjbp_fifo #(.W($bits(hjbp_pkg::t_res))) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (bk_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_matched = out_res.matched;
    assign o_probe_a = out_res.probe_a;
    assign o_probe_b = out_res.probe_b;
    assign o_build_a = out_res.build_a;
    assign o_build_b = out_res.build_b;
    assign o_status  = out_res.status;
    assign o_last    = out_res.last;

endmodule
